// ===== rtl/cbm_pkg.sv =====
// Shared types, codes and mask tables for the cartridge bank mapper.
// No dependencies; used by cbm_decode and cartridge_bank_mapper.
package cbm_pkg;

  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int EXT_W   = 23;
  localparam int ROMSZ_W = 4;
  localparam int RAMSZ_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;
  localparam int IN_DATA_W  = 24;  // address + byte
  localparam int OUT_DATA_W = 40;  // 23 + 8 + 8, padded to whole bytes

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 1'b1;

  localparam logic [BYTE_W-1:0] RAM_EN_KEY   = 8'h0A;
  localparam logic [BYTE_W-1:0] OPEN_BUS_VAL = 8'hFF;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_ROM_READ  = 2'd1,
    KIND_RAM_READ  = 2'd2,
    KIND_RAM_WRITE = 2'd3
  } access_kind_t;

  typedef struct packed {
    logic       ram_en;
    logic [7:0] rom_low;
    logic       rom_high;
    logic [3:0] ram_sel;
  } bank_state_t;

  typedef struct packed {
    access_kind_t      kind;
    logic [EXT_W-1:0]  ext_addr;
    logic [BYTE_W-1:0] wbyte;
    logic [BYTE_W-1:0] fixed;
  } map_result_t;

  // low ROM bank mask from header size code; codes above 7 saturate
  function automatic logic [7:0] rom_mask(input logic [ROMSZ_W-1:0] code);
    logic [7:0] m;
    case (code)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h03;
      4'd2:    m = 8'h07;
      4'd3:    m = 8'h0F;
      4'd4:    m = 8'h1F;
      4'd5:    m = 8'h3F;
      4'd6:    m = 8'h7F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // RAM bank mask; a single-bank part gets no select bits
  function automatic logic [3:0] ram_mask(input logic [RAMSZ_W-1:0] code);
    logic [3:0] m;
    case (code)
      3'd3:    m = 4'h3;
      3'd4:    m = 4'hF;
      3'd5:    m = 4'h7;
      default: m = 4'h0;
    endcase
    return m;
  endfunction

  function automatic logic ram_present(input logic [RAMSZ_W-1:0] code);
    return (code >= 3'd2) && (code <= 3'd5);
  endfunction

endpackage

// ===== rtl/cbm_decode.sv =====
// Address decode and bank mapping for one bus access.
// Purely combinational; uses cbm_pkg.
module cbm_decode import cbm_pkg::*; (
  input  logic                is_write,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [BYTE_W-1:0]   data,
  input  logic [ROMSZ_W-1:0]  rom_code,
  input  logic [RAMSZ_W-1:0]  ram_code,
  input  bank_state_t         st,
  output bank_state_t         st_nxt,
  output map_result_t         res
);

  logic ram_ok;
  logic in_ram_win;
  logic [8:0] rom_page;
  logic [EXT_W-1:0] ram_ext;

  assign ram_ok     = st.ram_en && ram_present(ram_code);
  assign in_ram_win = (addr >= 16'hA000) && (addr <= 16'hBFFF);
  assign rom_page   = {st.rom_high, st.rom_low};
  assign ram_ext    = {6'd0, st.ram_sel, addr[12:0]};

  always_comb begin
    st_nxt       = st;
    res.kind     = KIND_NONE;
    res.ext_addr = '0;
    res.wbyte    = '0;
    res.fixed    = '0;
    if (is_write) begin
      if (addr <= 16'h1FFF) begin
        st_nxt.ram_en = (data == RAM_EN_KEY);
      end else if (addr <= 16'h2FFF) begin
        st_nxt.rom_low = data & rom_mask(rom_code);
      end else if (addr <= 16'h3FFF) begin
        // small ROMs decode the whole 0x2000-0x3FFF range as low bank
        if (rom_code > 4'd7) begin
          st_nxt.rom_high = data[0];
        end else begin
          st_nxt.rom_low = data & rom_mask(rom_code);
        end
      end else if (addr <= 16'h5FFF) begin
        if (ram_ok) begin
          st_nxt.ram_sel = data[3:0] & ram_mask(ram_code);
        end
      end else if (in_ram_win && ram_ok) begin
        res.kind     = KIND_RAM_WRITE;
        res.ext_addr = ram_ext;
        res.wbyte    = data;
      end
    end else begin
      if (addr < 16'h4000) begin
        res.kind     = KIND_ROM_READ;
        res.ext_addr = {9'd0, addr[13:0]};
      end else if (addr < 16'h8000) begin
        res.kind     = KIND_ROM_READ;
        res.ext_addr = {rom_page, addr[13:0]};
      end else if (in_ram_win) begin
        if (ram_ok) begin
          res.kind     = KIND_RAM_READ;
          res.ext_addr = ram_ext;
        end else begin
          res.fixed = OPEN_BUS_VAL;
        end
      end
    end
  end

endmodule

// ===== rtl/cartridge_bank_mapper.sv =====
// Cartridge bank mapper top level: streaming ports, bank state, pipeline.
// Depends on cbm_pkg and cbm_decode.
// Pipeline: input register, then result register; out_tvalid comes from the result register.
// Throughput: one item per cycle; out_tready low holds both stages, input stalls when full.
// Reset (sync, active low): pipeline empty, RAM disabled, ROM bank 1:0, RAM bank 0, codes 0.
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input item
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [15:0] bus_address, [23:16] bus_data
  input  logic                   in_tuser,   // [0] req_type (1 = write)
  // result item
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [22:0] ext_address, [30:23] write_byte,
                                             // [38:31] fixed_value, [39] zero
  output logic [1:0]             out_tuser,  // [1:0] access_kind
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata
);

  // header size codes
  logic [ROMSZ_W-1:0] rom_code_r;
  logic [RAMSZ_W-1:0] ram_code_r;

  // input stage
  logic               s1_vld_r;
  logic               s1_wr_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [BYTE_W-1:0]  s1_data_r;

  // bank registers, updated as an item leaves the input stage
  bank_state_t        bank_r;
  bank_state_t        bank_nxt;

  // result stage
  logic               out_vld_r;
  map_result_t        res_r;
  map_result_t        res_nxt;

  logic               adv;   // input stage may move into the result stage

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;

  cbm_decode u_dec (
    .is_write (s1_wr_r),
    .addr     (s1_addr_r),
    .data     (s1_data_r),
    .rom_code (rom_code_r),
    .ram_code (ram_code_r),
    .st       (bank_r),
    .st_nxt   (bank_nxt),
    .res      (res_nxt)
  );

  // config writes must only arrive while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_code_r <= '0;
      ram_code_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROM_SIZE: rom_code_r <= cfg_wdata;
        CFG_RAM_SIZE: ram_code_r <= cfg_wdata[RAMSZ_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_wr_r   <= in_tuser;
      s1_addr_r <= in_tdata[15:0];
      s1_data_r <= in_tdata[23:16];
    end
  end

  // bank state commits exactly once per item, in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r.ram_en   <= 1'b0;
      bank_r.rom_low  <= 8'd1;
      bank_r.rom_high <= 1'b0;
      bank_r.ram_sel  <= 4'd0;
    end else if (s1_vld_r && adv) begin
      bank_r <= bank_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {1'b0, res_r.fixed, res_r.wbyte, res_r.ext_addr};

endmodule

// ===== test/cartridge_bank_mapper_tb.sv =====
// Self-checking testbench for cartridge_bank_mapper: a class predicts each mapped
// access and checks it, and plain tasks drive the stream and configuration ports.
// Depends on cbm_pkg and the cartridge_bank_mapper RTL.
`timescale 1ns / 1ps

module cartridge_bank_mapper_tb import cbm_pkg::*; ();

  localparam bit REQ_READ  = 1'b0;
  localparam bit REQ_WRITE = 1'b1;

  localparam int CLK_HALF     = 6;       // 12 ns period
  localparam int RESET_CYCLES = 10;
  localparam int HOLD_CYCLES  = 80;      // long receiver hold-off
  localparam int TAIL_CYCLES  = 10;      // pipeline is two deep; allow a margin
  localparam int CYCLE_LIMIT  = 200000;  // cycle budget for ~650 items, with margin
  localparam int REPORT_CAP   = 40;

  localparam int PHASES         = 10;
  localparam int ITEMS_PER_PHASE = 62;

  // bus map boundaries used by the stimulus
  localparam logic [15:0] ROM_BANKED = 16'h4000;
  localparam logic [15:0] RAM_BASE   = 16'hA000;
  localparam logic [15:0] RAM_TOP    = 16'hBFFF;

  // ---------------------------------------------------------------------------
  // Bank state tracker: mirrors the mapper's registers and queues the result
  // each accepted access should produce.
  // ---------------------------------------------------------------------------
  class bank_tracker;
    logic [3:0]  rom_code;
    logic [2:0]  ram_code;
    logic        ram_on;
    logic [7:0]  bank_low;
    logic        bank_high;
    logic [3:0]  ram_sel;
    map_result_t due_maps[$];
    int          errors;
    int          reports;
    int          kind_seen[4];

    function new();
      rom_code  = '0;
      ram_code  = '0;
      ram_on    = 1'b0;
      bank_low  = 8'h01;
      bank_high = 1'b0;
      ram_sel   = '0;
      errors    = 0;
      reports   = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == CFG_ROM_SIZE) rom_code = val[3:0];
      else ram_code = val[2:0];
    endfunction

    // codes past 7 saturate to a full byte mask
    function logic [7:0] low_mask();
      int m;
      if (rom_code == 0) return 8'h00;
      if (rom_code > 7) return 8'hFF;
      m = (1 << (rom_code + 1)) - 1;
      return m[7:0];
    endfunction

    function logic [3:0] sel_mask();
      case (ram_code)
        3'd3:    return 4'h3;
        3'd4:    return 4'hF;
        3'd5:    return 4'h7;
        default: return 4'h0;
      endcase
    endfunction

    function int pending();
      return due_maps.size();
    endfunction

    // work out the result of one accepted access and advance the bank state
    function void note_access(bit is_write, logic [15:0] addr, logic [7:0] data);
      map_result_t r;
      bit          ram_ok;
      bit          in_win;
      logic [8:0]  bank;
      ram_ok = ram_on && (ram_code >= 3'd2) && (ram_code <= 3'd5);
      in_win = (addr >= RAM_BASE) && (addr <= RAM_TOP);
      r = '0;
      r.kind = KIND_NONE;
      if (is_write) begin
        if (addr <= 16'h1FFF) begin
          ram_on = (data == RAM_EN_KEY);
        end else if (addr <= 16'h2FFF) begin
          bank_low = data & low_mask();
        end else if (addr <= 16'h3FFF) begin
          // small ROMs keep the low bank here too; big ones get the ninth bit
          if (rom_code > 7) bank_high = data[0];
          else bank_low = data & low_mask();
        end else if (addr <= 16'h5FFF) begin
          if (ram_ok) ram_sel = data[3:0] & sel_mask();
        end else if (in_win && ram_ok) begin
          r.kind     = KIND_RAM_WRITE;
          r.ext_addr = {6'd0, ram_sel, addr[12:0]};
          r.wbyte    = data;
        end
      end else begin
        if (addr < ROM_BANKED) begin
          r.kind     = KIND_ROM_READ;
          r.ext_addr = {9'd0, addr[13:0]};
        end else if (addr < 16'h8000) begin
          bank       = {bank_high, bank_low};
          r.kind     = KIND_ROM_READ;
          r.ext_addr = {bank, addr[13:0]};
        end else if (in_win) begin
          if (ram_ok) begin
            r.kind     = KIND_RAM_READ;
            r.ext_addr = {6'd0, ram_sel, addr[12:0]};
          end else begin
            r.fixed = OPEN_BUS_VAL;
          end
        end
      end
      due_maps.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (reports < REPORT_CAP)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      else if (reports == REPORT_CAP)
        $display("%0t: further mismatch reports suppressed", $time);
      reports++;
    endfunction

    function void check_mapping(access_kind_t kind, logic [EXT_W-1:0] ext,
                                logic [7:0] wb, logic [7:0] fx);
      map_result_t want;
      if (due_maps.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, kind %0d ext 0x%0h",
                 $time, kind, ext);
        return;
      end
      want = due_maps.pop_front();
      kind_seen[want.kind]++;
      if (kind !== want.kind)     flag("access_kind", want.kind, kind);
      if (ext  !== want.ext_addr) flag("ext_address", want.ext_addr, ext);
      if (wb   !== want.wbyte)    flag("write_byte", want.wbyte, wb);
      if (fx   !== want.fixed)    flag("fixed_value", want.fixed, fx);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT and stimulus signals; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [15:0] bus_address, [23:16] bus_data
  logic                  in_tuser   = 1'b0; // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [22:0] ext, [30:23] wbyte, [38:31] fixed
  logic [1:0]            out_tuser;        // [1:0] access_kind
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata  = '0;

  bank_tracker tracker = new();
  int  cycles      = 0;
  int  items_sent  = 0;
  int  settings    = 0;
  bit  quiet_tail  = 1'b0;  // no idling on either side
  bit  hold_req    = 1'b0;  // asks the receiver for one long hold-off

  cartridge_bank_mapper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog on a plain cycle count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, tracker.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Monitor: everything sampled as it stood before the edge. Config writes and
  // accepted items update the tracker; accepted results are checked in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.set_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready)
        tracker.note_access(in_tuser, in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready)
        tracker.check_mapping(access_kind_t'(out_tuser), out_tdata[22:0],
                              out_tdata[30:23], out_tdata[38:31]);
    end
  end

  // Receiver: random ready/stall bursts, one long hold-off on request, and
  // always ready in the quiet tail. One assignment per iteration, then time moves.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_tail) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 9) < 3) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until accepted; valid stays up for the next item
  // unless a gap is drawn.
  task automatic send_access(bit is_write, logic [15:0] addr, logic [7:0] data);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {data, addr};
    in_tuser  <= is_write;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_sizes(logic [3:0] rom_code, logic [2:0] ram_code);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROM_SIZE;
    cfg_wdata <= rom_code;
    @(posedge clk);
    cfg_index <= CFG_RAM_SIZE;
    cfg_wdata <= {1'b0, ram_code};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Mostly control sequences and window accesses with random content, so RAM
  // enable, bank selects and the quirky 0x3000 range are exercised in depth.
  task automatic send_random();
    int          pick;
    bit          wr;
    logic [15:0] addr;
    logic [7:0]  data;
    pick = $urandom_range(0, 99);
    data = 8'($urandom_range(0, 255));
    wr   = REQ_WRITE;
    if (pick < 15) begin
      addr = 16'($urandom_range(16'h0000, 16'h1FFF));
      if ($urandom_range(0, 9) < 7) data = RAM_EN_KEY;
    end else if (pick < 30) begin
      addr = 16'($urandom_range(16'h2000, 16'h3FFF));
    end else if (pick < 40) begin
      addr = 16'($urandom_range(16'h4000, 16'h5FFF));
    end else if (pick < 60) begin
      addr = 16'($urandom_range(RAM_BASE, RAM_TOP));
    end else if (pick < 80) begin
      addr = 16'($urandom_range(RAM_BASE, RAM_TOP));
      wr   = REQ_READ;
    end else if (pick < 95) begin
      addr = 16'($urandom_range(16'h0000, 16'h7FFF));
      wr   = REQ_READ;
    end else begin
      addr = 16'($urandom_range(0, 16'hFFFF));
      wr   = 1'($urandom_range(0, 1));
    end
    send_access(wr, addr, data);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  int rom_plan[PHASES] = '{0, 1, 7, 8, 15, 5, 8, -1, -1, 8};
  int ram_plan[PHASES] = '{0, 3, 5, 4, 7, 2, 1, -1, -1, 4};

  initial begin
    logic [3:0] rc;
    logic [2:0] mc;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state first: bank 1 mapped, RAM closed
    send_access(REQ_READ, 16'h4000, 8'h00);
    send_access(REQ_READ, 16'hA000, 8'h00);

    // big ROM, 16 RAM banks
    program_sizes(4'd8, 3'd4);
    send_access(REQ_READ,  16'h0000, 8'hFF);
    send_access(REQ_READ,  16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'h4000, 8'h03);  // select ignored, RAM still off
    send_access(REQ_WRITE, 16'h0000, RAM_EN_KEY);
    send_access(REQ_WRITE, 16'h5FFF, 8'hFF);
    send_access(REQ_WRITE, 16'hBFFF, 8'hA5);
    send_access(REQ_READ,  16'hA000, 8'h00);
    send_access(REQ_WRITE, 16'h2000, 8'hFF);
    send_access(REQ_WRITE, 16'h3000, 8'h01);  // ninth bank bit
    send_access(REQ_READ,  16'h4000, 8'h00);
    send_access(REQ_READ,  16'h8000, 8'h00);
    send_access(REQ_READ,  16'hFFFF, 8'h00);
    send_access(REQ_WRITE, 16'h6000, 8'h55);  // dead range
    send_access(REQ_WRITE, 16'hC000, 8'hAA);
    send_access(REQ_WRITE, 16'h1FFF, 8'h0B);  // closes RAM
    send_access(REQ_WRITE, 16'hA000, 8'h12);  // dropped

    // small ROM: 0x3000 range sets the low bank; single-bank RAM keeps stale select
    program_sizes(4'd3, 3'd2);
    send_access(REQ_WRITE, 16'h0000, RAM_EN_KEY);
    send_access(REQ_WRITE, 16'h3FFF, 8'hFF);
    send_access(REQ_READ,  16'h5000, 8'h00);
    send_access(REQ_READ,  16'hA123, 8'h00);
    send_access(REQ_WRITE, 16'h4000, 8'hFF);

    // out-of-table codes: ROM acts as code 8, RAM as absent
    program_sizes(4'd15, 3'd6);
    send_access(REQ_READ,  16'hB000, 8'h00);
    send_access(REQ_WRITE, 16'h3000, 8'hFE);
    send_access(REQ_WRITE, 16'h2FFF, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      rc = (rom_plan[p] < 0) ? 4'($urandom_range(0, 15)) : 4'(rom_plan[p]);
      mc = (ram_plan[p] < 0) ? 3'($urandom_range(0, 7))  : 3'(ram_plan[p]);
      program_sizes(rc, mc);
      if (p == PHASES - 1) quiet_tail = 1'b1;
      if (p == 3) hold_req = 1'b1;  // receiver backs off, input must stall
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 5 && i == ITEMS_PER_PHASE / 2) wait_drained();
        send_random();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d accesses over %0d size settings, hold-off and drain pauses included",
             items_sent, settings);
    $display("Results: %0d ROM reads, %0d RAM reads, %0d RAM writes, %0d without access",
             tracker.kind_seen[KIND_ROM_READ], tracker.kind_seen[KIND_RAM_READ],
             tracker.kind_seen[KIND_RAM_WRITE], tracker.kind_seen[KIND_NONE]);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", tracker.errors, tracker.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
